/* sv/art_pkg.sv */
`timescale 1ns / 1ps
package art_pkg;
    localparam int DepthDefault = 64;
    localparam int IdW = 32;
    localparam int TimeW = 16;
    localparam int RetryW = 4;
    localparam int TimeoutW = 8;
    localparam int CfgIdxW = 1;
    localparam int CfgDataW = 8;
    localparam logic [TimeoutW-1:0] TimeoutReset = 8'd2;
    localparam logic [RetryW-1:0] LimitReset = 4'd3;
    localparam logic [RetryW-1:0] RetryMax = 4'd15;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_ACK = 2'd1,
        OP_TICK = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        KIND_ADDED = 3'd0,
        KIND_FULL = 3'd1,
        KIND_ACKED = 3'd2,
        KIND_UNMATCHED = 3'd3,
        KIND_RESEND = 3'd4,
        KIND_DROPPED = 3'd5
    } kind_t;

    localparam logic [CfgIdxW-1:0] REG_TIMEOUT = 1'd0;
    localparam logic [CfgIdxW-1:0] REG_LIMIT = 1'd1;

    typedef struct packed {
        logic [1:0] op;
        logic [IdW-1:0] msg_id;
    } in_word_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [IdW-1:0] msg_id_res;
        logic [RetryW-1:0] retry_count;
        logic last;
    } out_word_t;
endpackage

/* sv/art_front.sv */
`timescale 1ns / 1ps
module art_front (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  art_pkg::in_word_t in_word,
    output logic q_valid,
    input  logic q_take,
    output art_pkg::in_word_t q_word
);
    import art_pkg::*;

    localparam int QD = 2;

    in_word_t mem_reg [QD];
    logic rd_ptr_reg, rd_ptr_next, wr_ptr_reg, wr_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic do_push, do_pop;

    // drop unused op codes at the door
    assign full = (cnt_reg == 2'(QD));
    assign do_push = push && !full && (in_word.op != OP_NONE);
    assign do_pop = q_take && q_valid;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_word = mem_reg[rd_ptr_reg];

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg + 1'(do_pop);
        wr_ptr_next = wr_ptr_reg + 1'(do_push);
        cnt_next = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= in_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule

/* sv/art_back.sv */
`timescale 1ns / 1ps
module art_back #(
    parameter int DEPTH = art_pkg::DepthDefault
) (
    input  logic clk,
    input  logic rst_n,
    input  logic q_valid,
    output logic q_take,
    input  art_pkg::in_word_t q_word,
    input  logic [art_pkg::TimeoutW-1:0] retry_timeout,
    input  logic [art_pkg::RetryW-1:0] retry_limit,
    output logic empty,
    input  logic pop,
    output art_pkg::out_word_t out_word,
    output logic idle
);
    import art_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_READ = 7'b0000010,
        S_EVAL = 7'b0000100,
        S_MOVE = 7'b0001000,
        S_MOVE2 = 7'b0010000,
        S_EMIT = 7'b0100000,
        S_DONE = 7'b1000000
    } st_t;

    logic [IdW-1:0] id_mem [DEPTH];
    logic [TimeW-1:0] sent_mem [DEPTH];
    logic [RetryW-1:0] ret_mem [DEPTH];

    st_t st_reg;
    logic [1:0] op_reg;
    logic [IdW-1:0] key_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg;
    logic [TimeW-1:0] now_reg;
    logic [IdW-1:0] rd_id_reg;
    logic [TimeW-1:0] rd_sent_reg;
    logic [RetryW-1:0] rd_ret_reg;
    logic found_reg;
    logic out_valid_reg;
    logic out_open_reg;
    out_word_t out_reg;
    out_word_t pend_reg;
    logic after_emit_idx_inc_reg;
    logic done_after_reg;

    logic [TimeW-1:0] age;
    logic [RetryW-1:0] rc_inc;
    logic [AW-1:0] idx_a;
    logic [CW-1:0] lastp;
    logic out_free;
    logic load_out;

    assign idx_a = idx_reg[AW-1:0];
    assign lastp = count_reg - CW'(1);
    assign age = now_reg - rd_sent_reg;
    assign rc_inc = (rd_ret_reg == RetryMax) ? rd_ret_reg : rd_ret_reg + RetryW'(1);
    assign out_free = !out_valid_reg || (pop && !out_open_reg);
    assign load_out = (st_reg == S_EMIT) && out_free;
    assign empty = !out_valid_reg || out_open_reg;
    assign out_word = out_reg;
    assign q_take = (st_reg == S_IDLE) && q_valid;
    assign idle = (st_reg == S_IDLE) && !q_valid && !out_valid_reg;

    // table read and write
    always_ff @(posedge clk)
    begin
        if (st_reg == S_READ)
        begin
            rd_id_reg <= id_mem[idx_a];
            rd_sent_reg <= sent_mem[idx_a];
            rd_ret_reg <= ret_mem[idx_a];
        end
        else if (st_reg == S_MOVE)
        begin
            rd_id_reg <= id_mem[count_reg[AW-1:0]];
            rd_sent_reg <= sent_mem[count_reg[AW-1:0]];
            rd_ret_reg <= ret_mem[count_reg[AW-1:0]];
        end
        if (st_reg == S_IDLE && q_valid && q_word.op == OP_ADD && count_reg < CW'(DEPTH))
        begin
            id_mem[count_reg[AW-1:0]] <= q_word.msg_id;
            sent_mem[count_reg[AW-1:0]] <= now_reg;
            ret_mem[count_reg[AW-1:0]] <= '0;
        end
        else if (st_reg == S_MOVE2)
        begin
            id_mem[idx_a] <= rd_id_reg;
            sent_mem[idx_a] <= rd_sent_reg;
            ret_mem[idx_a] <= rd_ret_reg;
        end
        else if (st_reg == S_EVAL && op_reg == OP_TICK
                 && age >= TimeW'(retry_timeout) && rc_inc <= retry_limit)
        begin
            sent_mem[idx_a] <= now_reg;
            ret_mem[idx_a] <= rc_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            count_reg <= '0;
            now_reg <= '0;
            out_valid_reg <= 1'b0;
            out_open_reg <= 1'b0;
            idx_reg <= '0;
            op_reg <= OP_NONE;
            found_reg <= 1'b0;
            after_emit_idx_inc_reg <= 1'b0;
            done_after_reg <= 1'b0;
        end
        else
        begin
            if (pop && !empty && !load_out)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (st_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        op_reg <= q_word.op;
                        key_reg <= q_word.msg_id;
                        idx_reg <= '0;
                        found_reg <= 1'b0;
                        if (q_word.op == OP_ADD)
                        begin
                            pend_reg.kind <= (count_reg < CW'(DEPTH)) ? KIND_ADDED : KIND_FULL;
                            pend_reg.msg_id_res <= q_word.msg_id;
                            pend_reg.retry_count <= '0;
                            pend_reg.last <= 1'b1;
                            if (count_reg < CW'(DEPTH))
                            begin
                                count_reg <= count_reg + CW'(1);
                            end
                            st_reg <= S_EMIT;
                            done_after_reg <= 1'b1;
                        end
                        else
                        begin
                            if (q_word.op == OP_TICK)
                            begin
                                now_reg <= now_reg + TimeW'(1);
                            end
                            st_reg <= S_DONE;
                        end
                    end
                end
                S_DONE:
                begin
                    // scan check: end of table
                    if (idx_reg >= count_reg)
                    begin
                        if (op_reg == OP_ACK && !found_reg)
                        begin
                            pend_reg.kind <= KIND_UNMATCHED;
                            pend_reg.msg_id_res <= key_reg;
                            pend_reg.retry_count <= '0;
                            pend_reg.last <= 1'b1;
                            done_after_reg <= 1'b1;
                            st_reg <= S_EMIT;
                        end
                        else
                        begin
                            if (op_reg == OP_TICK && found_reg)
                            begin
                                out_reg.last <= 1'b1;
                                out_open_reg <= 1'b0;
                            end
                            st_reg <= S_IDLE;
                        end
                    end
                    else
                    begin
                        st_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    st_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    if (op_reg == OP_ACK)
                    begin
                        if (rd_id_reg == key_reg)
                        begin
                            pend_reg.kind <= KIND_ACKED;
                            pend_reg.msg_id_res <= key_reg;
                            pend_reg.retry_count <= rd_ret_reg;
                            pend_reg.last <= 1'b1;
                            found_reg <= 1'b1;
                            count_reg <= lastp;
                            after_emit_idx_inc_reg <= 1'b0;
                            done_after_reg <= 1'b1;
                            st_reg <= S_MOVE;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + CW'(1);
                            st_reg <= S_DONE;
                        end
                    end
                    else if (age >= TimeW'(retry_timeout))
                    begin
                        pend_reg.msg_id_res <= rd_id_reg;
                        pend_reg.retry_count <= rc_inc;
                        pend_reg.last <= 1'b0;
                        done_after_reg <= 1'b0;
                        if (rc_inc > retry_limit)
                        begin
                            pend_reg.kind <= KIND_DROPPED;
                            count_reg <= lastp;
                            st_reg <= S_MOVE;
                        end
                        else
                        begin
                            pend_reg.kind <= KIND_RESEND;
                            after_emit_idx_inc_reg <= 1'b1;
                            st_reg <= S_EMIT;
                        end
                    end
                    else
                    begin
                        idx_reg <= idx_reg + CW'(1);
                        st_reg <= S_DONE;
                    end
                end
                S_MOVE:
                begin
                    // count already lowered: it now indexes the last entry
                    st_reg <= S_MOVE2;
                end
                S_MOVE2:
                begin
                    after_emit_idx_inc_reg <= 1'b0;
                    st_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    // hold one result back so last can be set at scan end
                    if (out_valid_reg && out_open_reg)
                    begin
                        out_open_reg <= 1'b0;
                    end
                    else if (out_free)
                    begin
                        out_reg <= pend_reg;
                        out_valid_reg <= 1'b1;
                        out_open_reg <= !pend_reg.last;
                        if (after_emit_idx_inc_reg)
                        begin
                            idx_reg <= idx_reg + CW'(1);
                        end
                        after_emit_idx_inc_reg <= 1'b0;
                        found_reg <= found_reg || (op_reg == OP_TICK);
                        st_reg <= done_after_reg ? S_IDLE : S_DONE;
                        done_after_reg <= 1'b0;
                    end
                end
                default:
                begin
                    st_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

/* sv/ack_retransmit_tracker.sv */
`timescale 1ns / 1ps
// Retransmission tracker for messages awaiting acknowledgement.
// Input channel: push/full carrying in_word (op, msg_id). Results: empty/pop
// carrying out_word (kind, msg_id_res, retry_count, last).
// A two-word input queue feeds a table engine that walks up to DEPTH entries
// through a single-port table, one entry at a time.
// Add: the word is taken in S_IDLE and its result loaded in S_EMIT.
// Ack and tick: taken in S_IDLE; each entry passed over takes S_DONE, S_READ,
// S_EVAL; a resend adds S_EMIT, a drop or matched ack S_MOVE, S_MOVE2, S_EMIT;
// an unmatched ack shows its result through S_EMIT after the scan ends.
// One item is processed at a time; the next waits in the input queue.
// Each result goes out through a one-word output register. A tick result stays
// hidden there until the next one arrives or the scan ends, so last can be set;
// the next result then waits for the pop.
// When the receiver stalls pop, the engine holds and the input queue fills.
// Ticks that age nothing give no result. Reset clears the entry count, tick
// counter, queues and sets retry_timeout to 2 and retry_limit to 3.
// Configuration writes apply at once; keeping them to idle is up to the user.
module ack_retransmit_tracker #(
    parameter int DEPTH = art_pkg::DepthDefault
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  art_pkg::in_word_t in_word,
    output logic empty,
    input  logic pop,
    output art_pkg::out_word_t out_word,
    input  logic cfg_we,
    input  logic [art_pkg::CfgIdxW-1:0] cfg_idx,
    input  logic [art_pkg::CfgDataW-1:0] cfg_data
);
    import art_pkg::*;

    logic q_valid, q_take, idle;
    in_word_t q_word;
    logic [TimeoutW-1:0] timeout_reg;
    logic [RetryW-1:0] limit_reg;
    logic b_empty;
    out_word_t b_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TimeoutReset;
            limit_reg <= LimitReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_TIMEOUT: timeout_reg <= cfg_data;
                REG_LIMIT: limit_reg <= cfg_data[RetryW-1:0];
                default: ;
            endcase
        end
    end

    art_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_word(in_word),
        .q_valid(q_valid), .q_take(q_take), .q_word(q_word)
    );

    art_back #(.DEPTH(DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_take(q_take),
        .q_word(q_word), .retry_timeout(timeout_reg), .retry_limit(limit_reg),
        .empty(b_empty), .pop(pop), .out_word(b_word), .idle(idle)
    );

    assign empty = b_empty;
    assign out_word = b_word;

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (out_word.kind <= KIND_DROPPED))
        else $error("bad result kind");
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        idle |-> empty)
        else $error("idle with pending result");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result lost");
endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
module tb;
    import art_pkg::*;

    localparam int Depth = 64;
    localparam int Drain = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    in_word_t in_word = '0;
    logic empty;
    logic pop = 1'b0;
    out_word_t out_word;
    logic cfg_we = 1'b0;
    logic [CfgIdxW-1:0] cfg_idx = '0;
    logic [CfgDataW-1:0] cfg_data = '0;

    ack_retransmit_tracker #(.DEPTH(Depth)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .in_word(in_word),
        .empty(empty),
        .pop(pop),
        .out_word(out_word),
        .cfg_we(cfg_we),
        .cfg_idx(cfg_idx),
        .cfg_data(cfg_data)
    );

    // table mirror
    logic [IdW-1:0] tbl_id [Depth];
    logic [TimeW-1:0] tbl_stamp [Depth];
    logic [RetryW-1:0] tbl_retries [Depth];
    int tbl_count = 0;
    logic [TimeW-1:0] now_tick = '0;
    logic [TimeoutW-1:0] timeout_reg = TimeoutReset;
    logic [RetryW-1:0] limit_reg = LimitReset;

    in_word_t pending_q [$];
    out_word_t events_q [$];
    logic [IdW-1:0] id_pool [12];
    int errors = 0;
    int popped = 0;

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic void add_event(kind_t k, logic [IdW-1:0] id, logic [RetryW-1:0] rc);
        out_word_t e;
        e.kind = k;
        e.msg_id_res = id;
        e.retry_count = rc;
        e.last = 1'b0;
        events_q.push_back(e);
    endfunction

    function automatic void remove_entry(int i);
        tbl_count--;
        tbl_id[i] = tbl_id[tbl_count];
        tbl_stamp[i] = tbl_stamp[tbl_count];
        tbl_retries[i] = tbl_retries[tbl_count];
    endfunction

    function automatic void track_word(in_word_t w);
        int n_before;
        int i;
        bit found;
        logic [TimeW-1:0] age;
        logic [RetryW-1:0] rc;
        logic [IdW-1:0] gone;
        n_before = events_q.size();
        found = 0;
        case (op_t'(w.op))
            OP_ADD:
            begin
                if (tbl_count < Depth)
                begin
                    tbl_id[tbl_count] = w.msg_id;
                    tbl_stamp[tbl_count] = now_tick;
                    tbl_retries[tbl_count] = '0;
                    tbl_count++;
                    add_event(KIND_ADDED, w.msg_id, '0);
                end
                else
                    add_event(KIND_FULL, w.msg_id, '0);
            end
            OP_ACK:
            begin
                for (i = 0; i < tbl_count && !found; i++)
                begin
                    if (tbl_id[i] == w.msg_id)
                    begin
                        rc = tbl_retries[i];
                        remove_entry(i);
                        add_event(KIND_ACKED, w.msg_id, rc);
                        found = 1;
                    end
                end
                if (!found)
                    add_event(KIND_UNMATCHED, w.msg_id, '0);
            end
            OP_TICK:
            begin
                now_tick = now_tick + 1'b1;
                i = 0;
                while (i < tbl_count)
                begin
                    age = now_tick - tbl_stamp[i];
                    if (age < timeout_reg)
                        i++;
                    else
                    begin
                        rc = tbl_retries[i];
                        if (rc != RetryMax)
                            rc = rc + 1'b1;
                        tbl_retries[i] = rc;
                        if (rc > limit_reg)
                        begin
                            gone = tbl_id[i];
                            remove_entry(i);
                            add_event(KIND_DROPPED, gone, rc);
                        end
                        else
                        begin
                            tbl_stamp[i] = now_tick;
                            add_event(KIND_RESEND, tbl_id[i], rc);
                            i++;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (events_q.size() > n_before)
            events_q[events_q.size()-1].last = 1'b1;
    endfunction

    // driver
    int burst_left = 4;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            in_word <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                track_word(in_word);
                void'(pending_q.pop_front());
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 20);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            if (gap_left > 0)
            begin
                gap_left--;
                push <= 1'b0;
            end
            else if (pending_q.size() > 0)
            begin
                push <= 1'b1;
                in_word <= pending_q[0];
            end
            else
                push <= 1'b0;
        end
    end

    // monitor
    int hold_left = 0;
    bit held = 0;
    int stall_mode = 0;

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t e;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                popped++;
                if (events_q.size() == 0)
                begin
                    $error("unexpected word kind=%0d id=%h", out_word.kind, out_word.msg_id_res);
                    errors++;
                end
                else
                begin
                    e = events_q.pop_front();
                    if (out_word.kind !== e.kind)
                    begin
                        $error("kind: expected %0d, got %0d", e.kind, out_word.kind);
                        errors++;
                    end
                    if (out_word.msg_id_res !== e.msg_id_res)
                    begin
                        $error("msg_id_res: expected %h, got %h", e.msg_id_res,
                               out_word.msg_id_res);
                        errors++;
                    end
                    if (out_word.retry_count !== e.retry_count)
                    begin
                        $error("retry_count: expected %0d, got %0d", e.retry_count,
                               out_word.retry_count);
                        errors++;
                    end
                    if (out_word.last !== e.last)
                    begin
                        $error("last: expected %0d, got %0d", e.last, out_word.last);
                        errors++;
                    end
                end
            end
            if (!held && popped == 120)
            begin
                held = 1;
                hold_left = 600;
            end
            if ($urandom_range(0, 63) == 0)
                stall_mode = $urandom_range(0, 2);
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (stall_mode == 0)
                pop <= 1'b1;
            else if (stall_mode == 1)
                pop <= ($urandom_range(0, 3) != 0);
            else
                pop <= ($urandom_range(0, 3) == 0);
        end
    end

    task automatic queue_word(op_t op, logic [IdW-1:0] id);
        in_word_t w;
        w.op = op;
        w.msg_id = id;
        pending_q.push_back(w);
    endtask

    task automatic settle();
        while (pending_q.size() != 0 || push || events_q.size() != 0)
            @(posedge clk);
        repeat (Drain) @(posedge clk);
    endtask

    task automatic write_regs(logic [TimeoutW-1:0] tmo, logic [RetryW-1:0] lim);
        settle();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= REG_TIMEOUT;
        cfg_data <= tmo;
        timeout_reg = tmo;
        @(posedge clk);
        cfg_idx <= REG_LIMIT;
        cfg_data <= CfgDataW'(lim);
        limit_reg = lim;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_words(int n, int tick_pct);
        int k;
        int r;
        for (k = 0; k < 12; k++)
            id_pool[k] = $urandom;
        for (k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < tick_pct)
                queue_word(OP_TICK, $urandom);
            else if (r < tick_pct + (100 - tick_pct) / 2)
                queue_word(OP_ADD, id_pool[$urandom_range(0, 11)]);
            else if (r < 95)
                queue_word(OP_ACK, ($urandom_range(0, 7) == 0) ? $urandom
                                                                 : id_pool[$urandom_range(0, 11)]);
            else if (r < 98)
                queue_word(OP_ADD, $urandom);
            else
                queue_word(OP_NONE, $urandom);
        end
    endtask

    initial
    begin
        int k;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        queue_word(OP_ADD, 32'h0000_0000);
        queue_word(OP_ADD, 32'hFFFF_FFFF);
        queue_word(OP_ADD, 32'hA5A5_5A5A);
        queue_word(OP_NONE, 32'h1234_5678);
        queue_word(OP_ACK, 32'hFFFF_FFFF);
        queue_word(OP_ACK, 32'h0BAD_F00D);
        for (k = 0; k < 10; k++)
            queue_word(OP_TICK, '0);
        queue_word(OP_ADD, 32'h5A5A_A5A5);
        queue_word(OP_ACK, 32'h5A5A_A5A5);
        queue_word(OP_TICK, 32'hFFFF_FFFF);
        queue_word(OP_ACK, 32'h0000_0000);

        write_regs(8'd1, 4'd0);
        random_words(30, 30);
        write_regs(8'd255, 4'd14);
        random_words(20, 20);
        for (k = 0; k < 260; k++)
            queue_word(OP_TICK, '0);
        write_regs(8'd0, 4'd15);
        random_words(30, 35);
        write_regs(8'd1, 4'd5);
        for (k = 0; k < 66; k++)
            queue_word(OP_ADD, $urandom);
        random_words(14, 40);
        write_regs(8'd2, 4'd3);
        random_words(10, 30);
        write_regs(8'($urandom_range(1, 6)), 4'($urandom_range(0, 14)));
        random_words(10, 30);

        settle();
        if (events_q.size() != 0)
            errors++;
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

/* ack_retransmit_tracker.f */
sv/art_pkg.sv
sv/art_front.sv
sv/art_back.sv
sv/ack_retransmit_tracker.sv
test/tb.sv
